### rtl/core/ubx_ack_detector_assert.svh
// assertion macros for the acknowledge detector
`ifndef UBX_ACK_DETECTOR_ASSERT_SVH
`define UBX_ACK_DETECTOR_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define UAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/uad_pkg.sv
// shared types and constants for the acknowledge detector
`timescale 1ns / 1ps

package uad_pkg;

	localparam int unsigned ACK_LEN = 10;
	localparam int unsigned POS_W = 4;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] SYNC_1 = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_2 = 8'h62;
	localparam logic [BYTE_W-1:0] ACK_CLASS_CODE = 8'h05;
	localparam logic [BYTE_W-1:0] ACK_ID_CODE = 8'h01;
	localparam logic [BYTE_W-1:0] LEN_LO = 8'h02;
	localparam logic [BYTE_W-1:0] LEN_HI = 8'h00;
	// fixed part of the running checksum over the header bytes
	localparam logic [BYTE_W-1:0] CKA_BASE = 8'h08;
	localparam logic [BYTE_W-1:0] CKB_BASE = 8'h2B;

	localparam logic [POS_W-1:0] POS_FULL = POS_W'(ACK_LEN);
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [BYTE_W-1:0] RST_ACK_CLASS = 8'd6;
	localparam logic [BYTE_W-1:0] RST_ACK_MSG_ID = 8'd36;
	localparam logic [ELAPSED_W-1:0] RST_TIMEOUT = 16'd3000;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_WAIT    = 2'd1,
		ST_ACKED   = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACK_CLASS  = 2'd0,
		REG_ACK_MSG_ID = 2'd1,
		REG_TIMEOUT    = 2'd2,
		REG_NONE       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    ack_class;
		logic [BYTE_W-1:0]    ack_msg_id;
		logic [ELAPSED_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] match_position;
	} result_t;

endpackage

### rtl/core/uad_expected.sv
// expected acknowledge byte at a given match position
`timescale 1ns / 1ps

module uad_expected
	import uad_pkg::*;
(
	input  logic [POS_W-1:0]  pos,
	input  logic [BYTE_W-1:0] ack_class,
	input  logic [BYTE_W-1:0] ack_msg_id,
	output logic [BYTE_W-1:0] exp_byte
);

	logic [BYTE_W-1:0] ck_a;
	logic [BYTE_W-1:0] ck_b;

	// closed form of the fletcher sums over the six checksummed bytes
	assign ck_a = CKA_BASE + ack_class + ack_msg_id;
	assign ck_b = CKB_BASE + {ack_class[BYTE_W-2:0], 1'b0} + ack_msg_id;

	always_comb begin
		unique case (pos)
			4'd0: exp_byte = SYNC_1;
			4'd1: exp_byte = SYNC_2;
			4'd2: exp_byte = ACK_CLASS_CODE;
			4'd3: exp_byte = ACK_ID_CODE;
			4'd4: exp_byte = LEN_LO;
			4'd5: exp_byte = LEN_HI;
			4'd6: exp_byte = ack_class;
			4'd7: exp_byte = ack_msg_id;
			4'd8: exp_byte = ck_a;
			4'd9: exp_byte = ck_b;
			default: exp_byte = '0;
		endcase
	end

endmodule

### rtl/core/uad_core.sv
// match and timeout state with its per-item update
`timescale 1ns / 1ps

module uad_core
	import uad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [1:0]        action,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	output result_t           res
);

	logic                 armed_q;
	logic [POS_W-1:0]     count_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	logic                 armed_d;
	logic [POS_W-1:0]     count_d;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [BYTE_W-1:0]    exp_byte;
	action_t              act;

	assign act = action_t'(action);

	uad_expected u_expected (
		.pos        (count_q),
		.ack_class  (cfg.ack_class),
		.ack_msg_id (cfg.ack_msg_id),
		.exp_byte   (exp_byte)
	);

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		armed_d = armed_q;
		count_d = count_q;
		elapsed_d = elapsed_q;
		res.status = armed_q ? ST_WAIT : ST_IDLE;
		unique case (act)
			ACT_START: begin
				armed_d = 1'b1;
				count_d = '0;
				elapsed_d = '0;
				res.status = ST_WAIT;
			end
			ACT_BYTE: begin
				if (armed_q) begin
					if (count_q < POS_FULL && rx_byte == exp_byte) begin
						count_d = count_q + 1'b1;
					end else begin
						count_d = '0;
					end
					if (count_d >= POS_FULL) begin
						armed_d = 1'b0;
						res.status = ST_ACKED;
					end else begin
						res.status = ST_WAIT;
					end
				end
			end
			ACT_TICK: begin
				if (armed_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > cfg.timeout_ticks) begin
						armed_d = 1'b0;
						res.status = ST_TIMEOUT;
					end else begin
						res.status = ST_WAIT;
					end
				end
			end
			ACT_NOP: begin
			end
			default: begin
			end
		endcase
		res.match_position = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			count_q <= '0;
			elapsed_q <= '0;
		end else if (adv) begin
			armed_q <= armed_d;
			count_q <= count_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

### rtl/core/ubx_ack_detector.sv
// acknowledge packet detector: top level with input and result registers
// usage
//   input channel (in_valid, in_stall, action, rx_byte): one transfer per item,
//   action is start, received byte, timer tick or no operation
//   result channel (out_valid, out_stall, status, match_position): exactly one
//   transfer per accepted item, in order
//   configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
//   ready; index 0 class, 1 message id, 2 timeout, index 3 is ignored
// timing
//   from input transfer to result valid an item passes the input register, where
//   the compare and counter logic feeds the result register; one item per cycle
//   is sustained while the result channel does not stall
// reset
//   asynchronous; block idle, position and tick count zero, registers back to
//   class 6, id 36, timeout 3000; no clearing pass
// stalls
//   a stalled result holds; the input register keeps taking transfers until it
//   is full, then in_stall rises until the result register frees up
`timescale 1ns / 1ps

module ubx_ack_detector
	import uad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [BYTE_W-1:0]     rx_byte,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [POS_W-1:0]      match_position,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	cfg_t cfg_q;

	// input register stage
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [BYTE_W-1:0] rx_s1;

	// result register
	logic              out_valid_q;
	result_t           res_q;
	result_t           res;

	// item in the input register moves on when the result register is free or drained
	logic adv;
	logic in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_class <= RST_ACK_CLASS;
			cfg_q.ack_msg_id <= RST_ACK_MSG_ID;
			cfg_q.timeout_ticks <= RST_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACK_CLASS:  cfg_q.ack_class <= cfg_data[BYTE_W-1:0];
				REG_ACK_MSG_ID: cfg_q.ack_msg_id <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data[ELAPSED_W-1:0];
				REG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	// stall only while the input register is full and cannot move on
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			rx_s1 <= rx_byte;
		end
	end

	// compare and timer logic, state advances with each item handed on
	uad_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.action  (action_s1),
		.rx_byte (rx_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign match_position = res_q.match_position;

	`include "ubx_ack_detector_assert.svh"

	`UAD_ASSERT_NOW(a_ack_full, out_valid && res_q.status == ST_ACKED, match_position == POS_FULL, "acknowledge reported without full match")
	`UAD_ASSERT_NOW(a_wait_short, out_valid && res_q.status == ST_WAIT, match_position < POS_FULL, "waiting with full match position")
	`UAD_ASSERT_NOW(a_stall_full, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled with room to move")
	`UAD_ASSERT_NEXT(a_adv_result, adv, out_valid, "handed-on item produced no result")

endmodule

### bench/tb_ubx_ack_detector.sv
// testbench for the acknowledge packet detector: directed cases, then random traffic
`timescale 1ns / 1ps

module tb_ubx_ack_detector;
	import uad_pkg::*;

	// quiet cycles with no transfer on any channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// long wait under the largest timeout, short enough to keep the run small
	localparam int LONG_WAIT_TICKS = 40;

	// receiver behaviour on the result channel
	typedef enum int {
		STALL_NONE,
		STALL_SCATTER,
		STALL_LONG
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            action = ACT_NOP;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [POS_W-1:0]      match_position;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_NONE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the configuration registers, reset values as in the block
	logic [BYTE_W-1:0]    cfg_class = RST_ACK_CLASS;
	logic [BYTE_W-1:0]    cfg_id = RST_ACK_MSG_ID;
	logic [ELAPSED_W-1:0] cfg_timeout = RST_TIMEOUT;

	// predicted detector state
	logic                 pred_armed = 1'b0;
	logic [POS_W-1:0]     pred_pos = '0;
	logic [ELAPSED_W-1:0] pred_elapsed = '0;

	// reports still owed by the block, oldest first
	result_t expected_reports[$];

	int          mismatches = 0;
	int          live_items = 0;
	int          burst_left = 0;
	int          gap_max = 0;
	int          stall_run = 0;
	stall_mode_t stall_mode = STALL_NONE;

	ubx_ack_detector uut (.*);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------
	// receiver: stall pattern chosen per test
	// scatter gives short random stalls, long gives alternating runs of
	// stall and flow with a random length drawn for each
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_SCATTER: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run <= $urandom_range(1, 12);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// result checker: every result transfer is matched against the oldest
	// outstanding report, field by field
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_reports
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d position %0d",
					$time, status, match_position);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, status);
					mismatches++;
				end
				if (match_position !== want.match_position) begin
					$display("%0t: match position mismatch, expected %0d, got %0d",
						$time, want.match_position, match_position);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// watchdog: any transfer on any channel counts as progress
	// ---------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// byte expected at a given packet position under the current class and id;
	// the last two are the fletcher checksum over the class byte to the id
	function automatic logic [BYTE_W-1:0] ack_byte(input logic [POS_W-1:0] pos);
		logic [BYTE_W-1:0] frame [8];
		logic [BYTE_W-1:0] ck_a;
		logic [BYTE_W-1:0] ck_b;
		int i;
		frame = '{SYNC_1, SYNC_2, ACK_CLASS_CODE, ACK_ID_CODE, LEN_LO, LEN_HI,
			cfg_class, cfg_id};
		ck_a = '0;
		ck_b = '0;
		for (i = 2; i < 8; i++) begin
			ck_a = ck_a + frame[i];
			ck_b = ck_b + ck_a;
		end
		if (pos < 8)
			return frame[pos];
		return (pos == 8) ? ck_a : ck_b;
	endfunction

	// advances the predicted state by one accepted item and queues its report
	task automatic track_ack_state(input action_t act, input logic [BYTE_W-1:0] data);
		result_t r;
		if (act == ACT_START || pred_armed)
			live_items++;
		r.status = pred_armed ? ST_WAIT : ST_IDLE;
		case (act)
		ACT_START: begin
			pred_armed = 1'b1;
			pred_pos = '0;
			pred_elapsed = '0;
			r.status = ST_WAIT;
		end
		ACT_BYTE: if (pred_armed) begin
			// a mismatching byte drops back to the start without a second look
			if (pred_pos < POS_FULL && data == ack_byte(pred_pos))
				pred_pos = pred_pos + 1'b1;
			else
				pred_pos = '0;
			if (pred_pos >= POS_FULL) begin
				pred_armed = 1'b0;
				r.status = ST_ACKED;
			end else begin
				r.status = ST_WAIT;
			end
		end
		ACT_TICK: if (pred_armed) begin
			// count saturates, so a timeout at the top never fires
			if (pred_elapsed != ELAPSED_MAX)
				pred_elapsed = pred_elapsed + 1'b1;
			if (pred_elapsed > cfg_timeout) begin
				pred_armed = 1'b0;
				r.status = ST_TIMEOUT;
			end else begin
				r.status = ST_WAIT;
			end
		end
		default: ;
		endcase
		r.match_position = pred_pos;
		expected_reports.push_back(r);
	endtask

	// ---------------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------------

	// sends one item; the sender works in bursts with random gaps between
	// them, valid stays high across a burst
	task automatic send_item(input action_t act, input logic [BYTE_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_ack_state(act, data);
	endtask

	// stops the sender and waits until every owed report has arrived
	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		burst_left = 0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	// one register write; the caller lowers cfg_valid after its last write
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_ACK_CLASS:  cfg_class = data[BYTE_W-1:0];
		REG_ACK_MSG_ID: cfg_id = data[BYTE_W-1:0];
		REG_TIMEOUT:    cfg_timeout = data;
		default: ;
		endcase
	endtask

	// rewrites all three registers once the pipeline is empty; upper data
	// bits of the byte-wide registers carry junk that must be dropped
	task automatic configure(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
		input logic [ELAPSED_W-1:0] tmo);
		wait_drained();
		write_reg(REG_ACK_CLASS, {8'($urandom), cls});
		write_reg(REG_ACK_MSG_ID, {8'($urandom), id});
		write_reg(REG_TIMEOUT, tmo);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// bytes, ticks and the spare action before anything is armed
	task automatic test_idle_items();
		send_item(ACT_NOP, 8'h00);
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_TICK, 8'hAA);
	endtask

	// full packet under the reset class and id, then a byte after the ack
	task automatic test_default_ack();
		int i;
		send_item(ACT_START, 8'h55);
		for (i = 0; i < ACK_LEN; i++)
			send_item(ACT_BYTE, ack_byte(POS_W'(i)));
		send_item(ACT_BYTE, SYNC_1);
	endtask

	// zero timeout: the first tick already exceeds it; also pokes the spare index
	task automatic test_timeout_zero();
		wait_drained();
		write_reg(REG_ACK_CLASS, 16'h00FF);
		write_reg(REG_ACK_MSG_ID, 16'hFF00);
		write_reg(REG_TIMEOUT, 16'h0000);
		write_reg(REG_NONE, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_item(ACT_START, 8'h00);
		send_item(ACT_BYTE, SYNC_1);
		send_item(ACT_TICK, 8'h00);
		send_item(ACT_TICK, 8'h00);
	endtask

	// broken packet drops to zero, start while armed restarts the wait
	task automatic test_mismatch_restart();
		configure(8'h00, 8'hFF, 16'hFFFF);
		send_item(ACT_START, 8'hFF);
		send_item(ACT_BYTE, SYNC_1);
		send_item(ACT_BYTE, SYNC_2);
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_BYTE, SYNC_1);
		send_item(ACT_START, 8'h00);
		send_item(ACT_NOP, 8'hFF);
	endtask

	// with the largest timeout a long run of ticks never expires; lowering
	// the timeout below the count while armed then takes effect on the next tick
	task automatic test_long_wait();
		int i;
		stall_mode = STALL_NONE;
		gap_max = 0;
		configure(cfg_class, cfg_id, 16'hFFFF);
		send_item(ACT_START, 8'h00);
		for (i = 0; i < LONG_WAIT_TICKS; i++)
			send_item(ACT_TICK, 8'($urandom));
		configure(cfg_class, cfg_id, 16'(LONG_WAIT_TICKS - 1));
		send_item(ACT_TICK, 8'h00);
	endtask

	// one phase of random traffic under one register setting; mostly packet
	// attempts with random corruption and interleaved ticks, the rest noise
	task automatic run_random_phase(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
		input logic [ELAPSED_W-1:0] tmo, input int n_items);
		int target;
		int pick;
		int i;
		configure(cls, id, tmo);
		target = live_items + n_items;
		while (live_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if (!pred_armed || $urandom_range(0, 3) == 0)
					send_item(ACT_START, 8'($urandom));
				for (i = 0; i < ACK_LEN; i++) begin
					if ($urandom_range(0, 9) == 0)
						send_item(ACT_TICK, 8'($urandom));
					if ($urandom_range(0, 19) == 0)
						send_item(ACT_BYTE, 8'($urandom));
					else
						send_item(ACT_BYTE, ack_byte(POS_W'(i)));
				end
			end else if (pick < 65) begin
				send_item(ACT_START, 8'($urandom));
			end else if (pick < 80) begin
				send_item(ACT_TICK, 8'($urandom));
			end else if (pick < 90) begin
				send_item(ACT_BYTE, 8'($urandom));
			end else if (pick < 95) begin
				send_item(ACT_NOP, 8'($urandom));
			end else begin
				send_item(action_t'($urandom_range(0, 3)), 8'($urandom));
			end
		end
	endtask

	// several register settings, extremes first, with varied idling
	task automatic test_random_traffic();
		int p;
		stall_mode = STALL_SCATTER;
		gap_max = 8;
		run_random_phase(RST_ACK_CLASS, RST_ACK_MSG_ID, RST_TIMEOUT, 65);
		stall_mode = STALL_LONG;
		gap_max = 0;
		run_random_phase(8'h00, 8'h00, 16'h0000, 65);
		stall_mode = STALL_NONE;
		gap_max = 20;
		run_random_phase(8'hFF, 8'hFF, 16'hFFFF, 65);
		for (p = 0; p < 5; p++) begin
			stall_mode = stall_mode_t'(p % 3);
			gap_max = (p % 2 == 0) ? 4 : 0;
			run_random_phase(8'($urandom), 8'($urandom),
				16'($urandom_range(3, 40)), 65);
		end
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_mode = STALL_SCATTER;
		gap_max = 3;
		test_idle_items();
		test_default_ack();
		test_timeout_zero();
		test_mismatch_restart();
		test_long_wait();
		test_random_traffic();

		// let the last reports out, then a short tail for anything spurious
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/uad_pkg.sv
rtl/core/uad_expected.sv
rtl/core/uad_core.sv
rtl/core/ubx_ack_detector.sv
bench/tb_ubx_ack_detector.sv
